// ===== rtl/debug_break_watch_monitor_assert.svh =====
// Assertion macros shared by the break/watch monitor modules.
`ifndef DEBUG_BREAK_WATCH_MONITOR_ASSERT_SVH
`define DEBUG_BREAK_WATCH_MONITOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DBWM_ASSERT_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define DBWM_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/dbwm_pkg.sv =====
// Constants, request codes, reply words and shared types of the break/watch monitor.
package dbwm_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int ADDR_BITS = 32;
   // Compared address width: the low ADDR_BITS bits of the 32-bit address field.
   localparam int CMP_BITS  = (ADDR_BITS < 32) ? ADDR_BITS : 32;

   localparam logic [3:0] REQ_FETCH    = 4'd0;
   localparam logic [3:0] REQ_ACCESS   = 4'd1;
   localparam logic [3:0] REQ_TRAP     = 4'd2;
   localparam logic [3:0] REQ_ERROR    = 4'd3;
   localparam logic [3:0] REQ_STOP     = 4'd4;
   localparam logic [3:0] REQ_SET_BP   = 4'd5;
   localparam logic [3:0] REQ_CLEAR_BP = 4'd6;
   localparam logic [3:0] REQ_SET_WP   = 4'd7;
   localparam logic [3:0] REQ_CLEAR_WP = 4'd8;
   localparam logic [3:0] REQ_CONNECT  = 4'd9;
   localparam logic [3:0] REQ_DETACH   = 4'd10;
   localparam logic [3:0] REQ_CONTINUE = 4'd11;

   localparam logic [31:0] W_CONT  = 32'h434F4E54;
   localparam logic [31:0] W_OK    = 32'h00004F4B;
   localparam logic [31:0] W_STOP0 = 32'h53494700;
   localparam logic [31:0] W_RESET = 32'h53494703;
   localparam logic [31:0] W_BP    = 32'h53494705;
   localparam logic [31:0] W_WP    = 32'h53494706;
   localparam logic [31:0] W_TRAP  = 32'h53494709;
   localparam logic [31:0] W_ERR   = 32'h54412030;

   localparam logic DEST_LINK = 1'b0;
   localparam logic DEST_CPU  = 1'b1;

   // Search token that walks the slot chain, one cell per cycle.
   typedef struct packed {
      logic valid;
      logic use_wp;   // compare watchpoint slots instead of breakpoint slots
      logic clear;    // invalidate the first slot whose address matches
      logic hit;      // a valid slot matched so far
      logic found;    // any slot matched so far, valid or not
   } probe_type;

endpackage

// ===== rtl/dbwm_cell.sv =====
// One breakpoint slot and one watchpoint slot with the search token stage between cells.
module dbwm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dbwm_pkg::CMP_BITS-1:0] cmp_addr,
   input  logic                          set_bp,
   input  logic                          set_wp,
   input  dbwm_pkg::probe_type           probe_in,
   output dbwm_pkg::probe_type           probe_out
);

   logic [dbwm_pkg::CMP_BITS-1:0] bp_addr_ff, bp_addr_in;
   logic [dbwm_pkg::CMP_BITS-1:0] wp_addr_ff, wp_addr_in;
   logic                          bp_act_ff, bp_act_in;
   logic                          wp_act_ff, wp_act_in;
   dbwm_pkg::probe_type           probe_ff, probe_in_next;
   logic                          match;
   logic                          act;
   logic                          do_clear;

   assign match    = probe_in.use_wp ? (wp_addr_ff == cmp_addr) : (bp_addr_ff == cmp_addr);
   assign act      = probe_in.use_wp ? wp_act_ff : bp_act_ff;
   assign do_clear = probe_in.valid & probe_in.clear & match & ~probe_in.found;

   always_comb begin
      bp_addr_in = bp_addr_ff;
      wp_addr_in = wp_addr_ff;
      bp_act_in  = bp_act_ff;
      wp_act_in  = wp_act_ff;
      if (set_bp) begin
         bp_addr_in = cmp_addr;
         bp_act_in  = 1'b1;
      end
      if (set_wp) begin
         wp_addr_in = cmp_addr;
         wp_act_in  = 1'b1;
      end
      if (do_clear) begin
         if (probe_in.use_wp) begin
            wp_act_in = 1'b0;
         end else begin
            bp_act_in = 1'b0;
         end
      end

      probe_in_next       = probe_in;
      probe_in_next.hit   = probe_in.hit | (act & match);
      probe_in_next.found = probe_in.found | match;
   end

   // Stored addresses reset to zero: a clear of address zero can match an unwritten slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         bp_addr_ff <= '0;
         wp_addr_ff <= '0;
         bp_act_ff  <= 1'b0;
         wp_act_ff  <= 1'b0;
         probe_ff   <= '0;
      end else begin
         bp_addr_ff <= bp_addr_in;
         wp_addr_ff <= wp_addr_in;
         bp_act_ff  <= bp_act_in;
         wp_act_ff  <= wp_act_in;
         probe_ff   <= probe_in_next;
      end
   end

   assign probe_out = probe_ff;

`include "debug_break_watch_monitor_assert.svh"

   `DBWM_ASSERT_NEXT(a_clear_first_only, probe_in.valid && probe_in.found && !set_bp && !set_wp, $stable(bp_act_ff) && $stable(wp_act_ff), "slot cleared after an earlier match")

endmodule

// ===== rtl/debug_break_watch_monitor.sv =====
// Top level of the break/watch monitor: request decode, slot chain and reply buffer.
//
// Requests are taken one at a time. Fetch, memory access and the two clear commands
// send a search token down a chain of NUM_SLOTS slot cells, one cell per cycle, so such a
// request occupies the block until the token leaves the last cell; every other request
// goes from decode straight to its last step. Replies (none, one or two per request)
// sit in a two-entry output buffer, so a new request is accepted while earlier replies
// still wait; a request only stalls at its last step if the buffer is not yet empty.
// rsp_tuser is 0 for a word to the debugger link and 1 for the continue signal to the
// processor; rsp_tlast marks the final reply of a request. There is no clearing pass:
// all slots are cleared by reset.
module debug_break_watch_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // addr[31:0], trap_value[63:32], slot[67:64], zero pad
   input  logic [4:0]  req_tuser,   // req_type[3:0], is_reset[4]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // word[31:0]
   output logic [0:0]  rsp_tuser,   // dest[0]
   output logic        rsp_tlast
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SWEEP  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [3:0]                    req_type_ff;
   logic [dbwm_pkg::CMP_BITS-1:0] req_addr_ff;
   logic [31:0]                   req_trap_ff;
   logic [3:0]                    req_slot_ff;
   logic                          req_is_reset_ff;
   logic                          start_ff, start_in;
   logic                          hit_ff;
   logic                          halted_ff, halted_in;
   logic                          debug_on_ff, debug_in;

   logic [1:0]  out_cnt_ff;
   logic [31:0] out0_word_ff, out1_word_ff;
   logic        out0_dest_ff, out1_dest_ff;
   logic        out0_last_ff, out1_last_ff;

   logic        req_accept;
   logic        rsp_accept;
   logic        needs_probe;
   logic        finish_go;
   logic [1:0]  res_n;
   logic [31:0] w0, w1;
   logic        d0, d1, l0, l1;
   logic        set_bp, set_wp;

   dbwm_pkg::probe_type probe_link [0:dbwm_pkg::NUM_SLOTS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_accept = rsp_tvalid & rsp_tready;
   assign finish_go  = (state_ff == ST_FINISH) && (out_cnt_ff == 2'd0);

   assign needs_probe = req_tuser[3:0] inside {dbwm_pkg::REQ_FETCH, dbwm_pkg::REQ_ACCESS,
                                               dbwm_pkg::REQ_CLEAR_BP, dbwm_pkg::REQ_CLEAR_WP};
   assign start_in = req_accept & needs_probe;

   // Token entering the chain; clears only act while halted.
   always_comb begin
      probe_link[0].valid  = start_ff;
      probe_link[0].use_wp = (req_type_ff == dbwm_pkg::REQ_ACCESS) ||
                             (req_type_ff == dbwm_pkg::REQ_CLEAR_WP);
      probe_link[0].clear  = halted_ff && ((req_type_ff == dbwm_pkg::REQ_CLEAR_BP) ||
                                           (req_type_ff == dbwm_pkg::REQ_CLEAR_WP));
      probe_link[0].hit    = 1'b0;
      probe_link[0].found  = 1'b0;
   end

   for (genvar i = 0; i < dbwm_pkg::NUM_SLOTS; i++) begin : g_cell
      dbwm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmp_addr  (req_addr_ff),
         .set_bp    (set_bp && finish_go && (int'(req_slot_ff) == i)),
         .set_wp    (set_wp && finish_go && (int'(req_slot_ff) == i)),
         .probe_in  (probe_link[i]),
         .probe_out (probe_link[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = needs_probe ? ST_SWEEP : ST_FINISH;
            end
         end
         ST_SWEEP: begin
            if (probe_link[dbwm_pkg::NUM_SLOTS].valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_cnt_ff == 2'd0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Reply and state update of the request at its last step.
   always_comb begin
      res_n     = 2'd0;
      w0        = dbwm_pkg::W_OK;
      d0        = dbwm_pkg::DEST_LINK;
      l0        = 1'b1;
      w1        = dbwm_pkg::W_CONT;
      d1        = dbwm_pkg::DEST_CPU;
      l1        = 1'b1;
      halted_in = halted_ff;
      debug_in  = debug_on_ff;
      set_bp    = 1'b0;
      set_wp    = 1'b0;
      unique case (req_type_ff)
         dbwm_pkg::REQ_CONNECT: begin
            debug_in = 1'b1;
         end
         dbwm_pkg::REQ_DETACH: begin
            debug_in = 1'b0;
            if (halted_ff) begin
               halted_in = 1'b0;
               res_n     = 2'd2;
               l0        = 1'b0;
            end
         end
         default: begin
            if (!halted_ff) begin
               // running: processor events
               res_n = 2'd1;
               w0    = dbwm_pkg::W_CONT;
               d0    = dbwm_pkg::DEST_CPU;
               case (req_type_ff)
                  dbwm_pkg::REQ_FETCH: begin
                     if (debug_on_ff && hit_ff) begin
                        halted_in = 1'b1;
                        w0        = dbwm_pkg::W_BP;
                        d0        = dbwm_pkg::DEST_LINK;
                     end
                  end
                  dbwm_pkg::REQ_ACCESS: begin
                     if (debug_on_ff && hit_ff) begin
                        halted_in = 1'b1;
                        res_n     = 2'd2;
                        w0        = dbwm_pkg::W_WP;
                        d0        = dbwm_pkg::DEST_LINK;
                        l0        = 1'b0;
                        w1        = 32'(req_addr_ff);
                        d1        = dbwm_pkg::DEST_LINK;
                     end
                  end
                  dbwm_pkg::REQ_TRAP: begin
                     if (debug_on_ff) begin
                        halted_in = 1'b1;
                        res_n     = 2'd2;
                        w0        = dbwm_pkg::W_TRAP;
                        d0        = dbwm_pkg::DEST_LINK;
                        l0        = 1'b0;
                        w1        = req_trap_ff;
                        d1        = dbwm_pkg::DEST_LINK;
                     end
                  end
                  dbwm_pkg::REQ_ERROR: begin
                     if (debug_on_ff) begin
                        halted_in = 1'b1;
                        w0        = dbwm_pkg::W_ERR;
                        d0        = dbwm_pkg::DEST_LINK;
                     end
                  end
                  dbwm_pkg::REQ_STOP: begin
                     halted_in = 1'b1;
                     w0        = req_is_reset_ff ? dbwm_pkg::W_RESET : dbwm_pkg::W_STOP0;
                     d0        = dbwm_pkg::DEST_LINK;
                  end
                  default: res_n = 2'd0;
               endcase
            end else begin
               // halted: debugger commands, events ignored
               res_n = 2'd1;
               case (req_type_ff)
                  dbwm_pkg::REQ_SET_BP: set_bp = 1'b1;
                  dbwm_pkg::REQ_SET_WP: set_wp = 1'b1;
                  dbwm_pkg::REQ_CLEAR_BP, dbwm_pkg::REQ_CLEAR_WP: begin
                     // slot already invalidated during the chain walk
                  end
                  dbwm_pkg::REQ_CONTINUE: begin
                     halted_in = 1'b0;
                     w0        = dbwm_pkg::W_CONT;
                     d0        = dbwm_pkg::DEST_CPU;
                  end
                  default: res_n = 2'd0;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         start_ff    <= 1'b0;
         halted_ff   <= 1'b0;
         debug_on_ff <= 1'b0;
         out_cnt_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         if (finish_go) begin
            halted_ff   <= halted_in;
            debug_on_ff <= debug_in;
            out_cnt_ff  <= res_n;
         end else if (rsp_accept) begin
            out_cnt_ff <= (out_cnt_ff == 2'd2) ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_type_ff     <= req_tuser[3:0];
         req_is_reset_ff <= req_tuser[4];
         req_addr_ff     <= req_tdata[dbwm_pkg::CMP_BITS-1:0];
         req_trap_ff     <= req_tdata[63:32];
         req_slot_ff     <= req_tdata[67:64];
      end
      if (probe_link[dbwm_pkg::NUM_SLOTS].valid) begin
         hit_ff <= probe_link[dbwm_pkg::NUM_SLOTS].hit;
      end
      if (finish_go) begin
         out0_word_ff <= w0;
         out0_dest_ff <= d0;
         out0_last_ff <= l0;
         out1_word_ff <= w1;
         out1_dest_ff <= d1;
         out1_last_ff <= l1;
      end else if (rsp_accept) begin
         out0_word_ff <= out1_word_ff;
         out0_dest_ff <= out1_dest_ff;
         out0_last_ff <= out1_last_ff;
      end
   end

   assign rsp_tvalid   = (out_cnt_ff != 2'd0);
   assign rsp_tdata    = out0_word_ff;
   assign rsp_tuser[0] = out0_dest_ff;
   assign rsp_tlast    = out0_last_ff;

`include "debug_break_watch_monitor_assert.svh"

   `DBWM_ASSERT_IMPLY(a_token_in_sweep, probe_link[dbwm_pkg::NUM_SLOTS].valid, state_ff == ST_SWEEP, "chain token returned outside sweep")
   `DBWM_ASSERT_IMPLY(a_pair_not_last, out_cnt_ff == 2'd2, !out0_last_ff, "first of two replies marked last")
   `DBWM_ASSERT_NEXT(a_accept_busy, req_accept, state_ff != ST_IDLE, "request accepted but block stayed idle")

endmodule
